FILE: hw/rtl/grc_pkg.sv
// Shared types, constants and the quarter-wave sine table of the grid raycaster.
package grc_pkg;

   localparam int MAP_DIM_MAX = 64;
   localparam int MAP_DIM_BITS = $clog2(MAP_DIM_MAX);
   localparam int CELL_COUNT = MAP_DIM_MAX * MAP_DIM_MAX;
   localparam int CELL_BITS = $clog2(CELL_COUNT);
   localparam int SINE_DEPTH = 256;
   localparam int SINE_BITS = $clog2(SINE_DEPTH);

   localparam int REQ_WIDTH = 72;
   localparam int RSP_WIDTH = 56;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 19;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIELD_OF_VIEW = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_WIDTH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_DISTANCE = 3'd5;

   localparam logic CMD_WRITE_CELL = 1'b0;
   localparam logic CMD_CAST_RAY = 1'b1;

   localparam logic [19:0] STEP_Q12 = 20'd41;
   localparam logic [19:0] DIST_LIMIT = 20'h7FFFF;
   localparam logic [18:0] MIN_DIST_Q12 = 19'd410;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int DIV_WIDTH = 34;
   localparam int DIVISOR_WIDTH = 19;

   typedef logic [15:0] sine_tab_type [SINE_DEPTH];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG_START,
      ST_ANG_WAIT,
      ST_SETUP,
      ST_MARCH,
      ST_CHECK,
      ST_TEST,
      ST_ROW_START,
      ST_ROW_WAIT,
      ST_RESULT
   } grc_state_type;

   typedef struct packed {
      logic load;
      logic div_ang;
      logic ang_latch;
      logic setup;
      logic step;
      logic probe;
      logic hit;
      logic miss;
      logic div_row;
      logic result;
   } grc_cmd_type;

   typedef struct packed {
      logic is_cast;
      logic div_done;
      logic dist_over;
      logic off_map;
      logic cell_wall;
      logic out_free;
   } grc_status_type;

   function automatic logic [15:0] sine_entry(input int i);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      x = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
      term = x;
      sum = x;
      for (int k = 1; k <= 8; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + 64'd16384) >> 15;
      return (r > 64'd32767) ? 16'd32767 : r[15:0];
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type t;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         t[i] = sine_entry(i);
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TABLE = build_sine();

endpackage

FILE: hw/rtl/grid_raycast_column_core.sv
// Top level of the grid raycaster column core.
//
// The req channel takes one command beat at a time: either a write of one
// wall map cell, or the cast of one screen column's ray from the player pose.
// Every command gives exactly one beat on the rsp channel; a cell write
// answers with an all-zero beat.
// A cell write goes from the angle-start state straight to the result. A ray
// cast runs two divisions (the column angle and the wall height) and a step
// loop of position update, bound check and map read. A long ray may take up
// to about 12,800 steps. The csr port writes one configuration register per
// cycle. The user must write it only while idle; the block itself does not
// enforce this. Reset restores the register defaults and empties both
// channels; the map contents are undefined until written.
// A finished result waits in the output register while the receiver stalls;
// the next command is accepted meanwhile, and its result is held back until
// the output register is free.
module grid_raycast_column_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // command, cell_index, cell_is_wall, player_x, player_y, player_angle, column
   input  logic [grc_pkg::REQ_WIDTH-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit_wall, wall_distance, texture_u, ceiling_row, floor_row
   output logic [grc_pkg::RSP_WIDTH-1:0]       rsp_tdata,
   input  logic                                csr_we,
   input  logic [grc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [grc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import grc_pkg::*;

   grc_cmd_type cmd;
   grc_status_type status;

   grc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   grc_dp u_dp (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd(cmd),
      .status(status)
   );

endmodule

FILE: hw/rtl/grc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module grc_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [grc_pkg::DIV_WIDTH-1:0]        dividend,
   input  logic [grc_pkg::DIVISOR_WIDTH-1:0]    divisor,
   output logic                                 done,
   output logic [grc_pkg::DIV_WIDTH-1:0]        quotient
);
   import grc_pkg::*;

   localparam int CNT_WIDTH = $clog2(DIV_WIDTH + 1);

   logic [DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] den_ff, den_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIVISOR_WIDTH:0] shifted;
   logic [DIVISOR_WIDTH:0] diff;

   always_comb begin
      shifted = {rem_ff[DIVISOR_WIDTH-1:0], quo_ff[DIV_WIDTH-1]};
      diff = shifted - {1'b0, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff;
            quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(DIV_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/grc_ctrl.sv
// Controller state machine that sequences cell writes and ray casts.
module grc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  grc_pkg::grc_status_type status,
   output grc_pkg::grc_cmd_type    cmd
);
   import grc_pkg::*;

   grc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_ANG_START;
         ST_ANG_START: state_in = status.is_cast ? ST_ANG_WAIT : ST_RESULT;
         ST_ANG_WAIT: if (status.div_done) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_MARCH;
         ST_MARCH: state_in = status.dist_over ? ST_ROW_START : ST_CHECK;
         ST_CHECK: state_in = status.off_map ? ST_ROW_START : ST_TEST;
         ST_TEST: state_in = status.cell_wall ? ST_ROW_START : ST_MARCH;
         ST_ROW_START: state_in = ST_ROW_WAIT;
         ST_ROW_WAIT: if (status.div_done) state_in = ST_RESULT;
         ST_RESULT: if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         ST_ANG_START: cmd.div_ang = status.is_cast;
         ST_ANG_WAIT: cmd.ang_latch = status.div_done;
         ST_SETUP: cmd.setup = 1'b1;
         ST_MARCH: begin
            cmd.miss = status.dist_over;
            cmd.step = !status.dist_over;
         end
         ST_CHECK: begin
            cmd.miss = status.off_map;
            cmd.probe = !status.off_map;
         end
         ST_TEST: cmd.hit = status.cell_wall;
         ST_ROW_START: cmd.div_row = 1'b1;
         ST_ROW_WAIT: ;
         ST_RESULT: cmd.result = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/grc_dp.sv
// Datapath: registers, wall map memory, sine lookup, ray march and row math.
module grc_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [grc_pkg::REQ_WIDTH-1:0]          req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [grc_pkg::RSP_WIDTH-1:0]          rsp_tdata,
   input  logic                                   csr_we,
   input  logic [grc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [grc_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  grc_pkg::grc_cmd_type                   cmd,
   output grc_pkg::grc_status_type                status
);
   import grc_pkg::*;

   logic [10:0] sw_ff;
   logic [9:0] sh_ff;
   logic [15:0] fov_ff;
   logic [6:0] mw_ff, mh_ff;
   logic [18:0] maxd_ff;

   logic cmd_ff;
   logic [15:0] px_ff, py_ff, pa_ff;
   logic [9:0] col_ff;

   logic [15:0] ang_ff;
   logic signed [22:0] stx_ff, sty_ff;
   logic signed [36:0] rx_ff, ry_ff, rx_in, ry_in;
   logic [19:0] dist_ff, dist_next;
   logic rd_ff;
   logic hit_ff;
   logic [18:0] fin_ff, fin_in;
   logic [11:0] tex_ff, tex_in;

   logic out_valid_ff;
   logic [RSP_WIDTH-1:0] out_ff;

   logic mem [CELL_COUNT];

   logic div_start;
   logic [DIV_WIDTH-1:0] div_dividend;
   logic [DIVISOR_WIDTH-1:0] div_divisor;
   logic div_done;
   logic [DIV_WIDTH-1:0] div_quo;

   logic [6:0] mw_lim, mh_lim;
   logic [9:0] cx, cy;
   logic [12:0] cell_prod;
   logic [CELL_BITS-1:0] cell_addr;
   logic signed [16:0] dx, dy;
   logic [15:0] ang_in;
   logic [10:0] sw_eff;
   logic [25:0] col_prod;

   logic signed [27:0] ox, oy, ax, ay;
   logic use_x;
   logic signed [35:0] c_val;
   logic [9:0] ceil_row, floor_row;

   function automatic logic signed [16:0] sine_q15(input logic [15:0] a);
      logic [1:0] quad;
      logic [SINE_BITS:0] idx;
      logic [SINE_BITS:0] j;
      logic signed [16:0] v;
      quad = a[15:14];
      idx = {1'b0, a[13:14-SINE_BITS]};
      j = quad[0] ? ((SINE_BITS+1)'(SINE_DEPTH) - idx) : idx;
      v = j[SINE_BITS] ? 17'sd32768 : $signed({1'b0, SINE_TABLE[j[SINE_BITS-1:0]]});
      return quad[1] ? -v : v;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= 11'd320;
         sh_ff <= 10'd200;
         fov_ff <= 16'd8192;
         mw_ff <= 7'd16;
         mh_ff <= 7'd16;
         maxd_ff <= 19'd92681;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH: sw_ff <= csr_wdata[10:0];
            CSR_SCREEN_HEIGHT: sh_ff <= csr_wdata[9:0];
            CSR_FIELD_OF_VIEW: fov_ff <= csr_wdata[15:0];
            CSR_MAP_WIDTH: mw_ff <= csr_wdata[6:0];
            CSR_MAP_HEIGHT: mh_ff <= csr_wdata[6:0];
            CSR_MAX_DISTANCE: maxd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mw_lim = (mw_ff > 7'(MAP_DIM_MAX)) ? 7'(MAP_DIM_MAX) : mw_ff;
      mh_lim = (mh_ff > 7'(MAP_DIM_MAX)) ? 7'(MAP_DIM_MAX) : mh_ff;
      sw_eff = (sw_ff == '0) ? 11'd1 : sw_ff;
      col_prod = col_ff * fov_ff;
      ang_in = pa_ff - {1'b0, fov_ff[15:1]} + div_quo[15:0];
      dx = sine_q15(ang_ff);
      dy = sine_q15(ang_ff + 16'h4000);
      dist_next = dist_ff + STEP_Q12;
      rx_in = rx_ff + 37'(stx_ff);
      ry_in = ry_ff + 37'(sty_ff);
      cx = rx_ff[36:27];
      cy = ry_ff[36:27];
      cell_prod = cx[MAP_DIM_BITS-1:0] * mh_lim;
      cell_addr = CELL_BITS'(cell_prod) + CELL_BITS'(cy[MAP_DIM_BITS-1:0]);
   end

   // Texture coordinate of the hit point and the final distance.
   always_comb begin
      ox = $signed({1'b0, rx_ff[26:0]}) - 28'sh4000000;
      oy = $signed({1'b0, ry_ff[26:0]}) - 28'sh4000000;
      ax = ox[27] ? -ox : ox;
      ay = oy[27] ? -oy : oy;
      priority if (ax > ay) begin
         use_x = 1'b0;
      end else if (ax < ay) begin
         use_x = 1'b1;
      end else begin
         use_x = (ox != '0) && (ox[27] == oy[27]);
      end
      tex_in = use_x ? rx_ff[26:15] : ry_ff[26:15];
      fin_in = cmd.hit ? dist_ff[18:0] : maxd_ff;
      if (fin_in < MIN_DIST_Q12) begin
         fin_in = MIN_DIST_Q12;
      end
   end

   always_comb begin
      div_start = cmd.div_ang | cmd.div_row;
      if (cmd.div_row) begin
         div_dividend = {sh_ff, 24'b0};
         div_divisor = fin_ff;
      end else begin
         div_dividend = DIV_WIDTH'(col_prod);
         div_divisor = DIVISOR_WIDTH'(sw_eff);
      end
   end

   grc_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dividend),
      .divisor(div_divisor),
      .done(div_done),
      .quotient(div_quo)
   );

   always_comb begin
      c_val = $signed({15'b0, sh_ff, 11'b0}) - $signed({2'b0, div_quo});
      ceil_row = (!c_val[35] && (c_val != '0)) ? c_val[21:12] : 10'd0;
      floor_row = sh_ff - ceil_row;
   end

   // Item registers and the ray march.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_tdata[0];
         px_ff <= req_tdata[29:14];
         py_ff <= req_tdata[45:30];
         pa_ff <= req_tdata[61:46];
         col_ff <= req_tdata[71:62];
      end
      if (cmd.ang_latch) begin
         ang_ff <= ang_in;
      end
      if (cmd.setup) begin
         stx_ff <= dx * 23'sd41;
         sty_ff <= dy * 23'sd41;
         rx_ff <= $signed({4'b0, px_ff, 17'b0});
         ry_ff <= $signed({4'b0, py_ff, 17'b0});
         dist_ff <= '0;
      end else if (cmd.step) begin
         dist_ff <= dist_next;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
      if (cmd.hit || cmd.miss) begin
         hit_ff <= cmd.hit;
         fin_ff <= fin_in;
         tex_ff <= cmd.hit ? tex_in : 12'd0;
      end
   end

   // Wall map memory.
   always_ff @(posedge clock) begin
      if (cmd.load && req_tdata[0] == CMD_WRITE_CELL) begin
         mem[req_tdata[12:1]] <= req_tdata[13];
      end
      if (cmd.probe) begin
         rd_ff <= mem[cell_addr];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.result) begin
         if (cmd_ff == CMD_CAST_RAY) begin
            out_ff <= {4'b0, floor_row, ceil_row, tex_ff, fin_ff, hit_ff};
         end else begin
            out_ff <= '0;
         end
      end
   end

   always_comb begin
      status.is_cast = (cmd_ff == CMD_CAST_RAY);
      status.div_done = div_done;
      status.dist_over = (dist_next > DIST_LIMIT);
      status.off_map = rx_ff[36] | ry_ff[36] | (cx >= {3'b0, mw_lim})
                       | (cy >= {3'b0, mh_lim});
      status.cell_wall = rd_ff;
      status.out_free = !out_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_ff;

endmodule

FILE: tb/grid_raycast_column_core_test.sv
// Self-checking testbench for the grid raycaster column core.
`timescale 1ns / 1ps

module grid_raycast_column_core_test;
   import grc_pkg::*;

   // Every map configuration in the regs table below stays within this many cells.
   localparam int FILL_CELLS = 128;

   typedef struct {
      logic        hit;
      logic [18:0] distance;
      logic [11:0] tex;
      logic [9:0]  ceil_row;
      logic [9:0]  floor_row;
   } column_type;

   class column_scoreboard;
      int unsigned screen_w, screen_h, fov, map_w, map_h, max_dist;
      bit walls [CELL_COUNT];
      column_type columns_due[$];
      int errors;

      function void reset_regs();
         screen_w = 320; screen_h = 200; fov = 8192;
         map_w = 16; map_h = 16; max_dist = 92681;
      endfunction

      function void set_reg(logic [2:0] idx, logic [18:0] v);
         case (idx)
            CSR_SCREEN_WIDTH: screen_w = v[10:0];
            CSR_SCREEN_HEIGHT: screen_h = v[9:0];
            CSR_FIELD_OF_VIEW: fov = v[15:0];
            CSR_MAP_WIDTH: map_w = v[6:0];
            CSR_MAP_HEIGHT: map_h = v[6:0];
            CSR_MAX_DISTANCE: max_dist = v;
            default: ;
         endcase
      endfunction

      function int sine_q15(logic [15:0] a);
         int unsigned j;
         int v;
         j = (int'(a[13:0]) * SINE_DEPTH) >> 14;
         if (a[14]) j = SINE_DEPTH - j;
         v = (j >= SINE_DEPTH) ? 32768 : int'(SINE_TABLE[j]);
         return a[15] ? -v : v;
      endfunction

      function void note_input(logic [REQ_WIDTH-1:0] d);
         column_type r;
         int unsigned sw, mw, mh, ray_len, cx, cy;
         logic [15:0] ang;
         longint dx, dy, px, py, rx, ry, fx, fy, ox, oy, ax, ay, c, hh;
         bit hit, use_x;
         r = '{0, 0, 0, 0, 0};
         if (d[0] == CMD_WRITE_CELL) begin
            walls[d[12:1]] = d[13];
            columns_due.push_back(r);
            return;
         end
         sw = (screen_w == 0) ? 1 : screen_w;
         ang = 16'(d[61:46] - (fov >> 1) + (d[71:62] * fov) / sw);
         dx = sine_q15(ang);
         dy = sine_q15(ang + 16'h4000);
         mw = (map_w > MAP_DIM_MAX) ? MAP_DIM_MAX : map_w;
         mh = (map_h > MAP_DIM_MAX) ? MAP_DIM_MAX : map_h;
         px = longint'(d[29:14]) << 17;
         py = longint'(d[45:30]) << 17;
         ray_len = 0; hit = 0; rx = 0; ry = 0;
         forever begin
            ray_len += 41;
            if (ray_len > 32'h7FFFF) break;
            rx = px + dx * ray_len;
            ry = py + dy * ray_len;
            if (rx < 0 || ry < 0) break;
            cx = 32'(rx >> 27);
            cy = 32'(ry >> 27);
            if (cx >= mw || cy >= mh) break;
            if (walls[cx * mh + cy]) begin
               hit = 1;
               break;
            end
         end
         if (hit) begin
            fx = rx & ((64'd1 << 27) - 1);
            fy = ry & ((64'd1 << 27) - 1);
            ox = fx - (64'd1 << 26);
            oy = fy - (64'd1 << 26);
            ax = ox < 0 ? -ox : ox;
            ay = oy < 0 ? -oy : oy;
            if (ax > ay) use_x = 0;
            else if (ax < ay) use_x = 1;
            else use_x = (ox != 0) && ((ox > 0) == (oy > 0));
            r.tex = 12'((use_x ? fx : fy) >> 15);
         end else begin
            ray_len = max_dist;
         end
         if (ray_len < 410) ray_len = 410;
         hh = screen_h;
         c = hh * 2048 - (hh << 24) / ray_len;
         r.hit = hit;
         r.distance = 19'(ray_len);
         r.ceil_row = (c > 0) ? 10'(c >> 12) : 10'd0;
         r.floor_row = 10'(hh - r.ceil_row);
         columns_due.push_back(r);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check(logic [RSP_WIDTH-1:0] d);
         column_type e;
         if (columns_due.size() == 0) begin
            report("unexpected beat", d, 0);
            return;
         end
         e = columns_due.pop_front();
         if (d[0] !== e.hit) report("hit_wall", d[0], e.hit);
         if (d[19:1] !== e.distance) report("wall_distance", d[19:1], e.distance);
         if (d[31:20] !== e.tex) report("texture_u", d[31:20], e.tex);
         if (d[41:32] !== e.ceil_row) report("ceiling_row", d[41:32], e.ceil_row);
         if (d[51:42] !== e.floor_row) report("floor_row", d[51:42], e.floor_row);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_WIDTH-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   column_scoreboard sb;
   int send_idle_pct, recv_idle_pct;

   grid_raycast_column_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task send_beat(logic [REQ_WIDTH-1:0] d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_input(d);
   endtask

   task write_cell(int unsigned idx, bit wall);
      send_beat({58'd0, wall, 12'(idx), CMD_WRITE_CELL});
   endtask

   task cast(logic [15:0] x, logic [15:0] y, logic [15:0] ang, logic [9:0] col);
      send_beat({col, ang, y, x, 1'b0, 12'd0, CMD_CAST_RAY});
   endtask

   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.columns_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_reg(logic [2:0] idx, logic [18:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task random_beat();
      int unsigned mw, mh;
      logic [15:0] x, y;
      if ($urandom_range(0, 99) < 20) begin
         write_cell($urandom_range(0, FILL_CELLS - 1), $urandom_range(0, 99) < 35);
         return;
      end
      mw = (sb.map_w > MAP_DIM_MAX) ? MAP_DIM_MAX : sb.map_w;
      mh = (sb.map_h > MAP_DIM_MAX) ? MAP_DIM_MAX : sb.map_h;
      x = 16'($urandom);
      y = 16'($urandom);
      if ($urandom_range(0, 9) != 0 && mw != 0 && mh != 0) begin
         x = 16'($urandom_range(0, mw * 1024 - 1));
         y = 16'($urandom_range(0, mh * 1024 - 1));
      end
      cast(x, y, 16'($urandom), 10'($urandom_range(0, 1023)));
   endtask

   initial begin
      #(12ns * 60_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [18:0] regs [6][6];
      sb = new();
      sb.reset_regs();
      regs[0] = '{320, 200, 8192, 8, 16, 92681};
      regs[1] = '{1, 1, 1, 64, 2, 0};
      regs[2] = '{1024, 512, 32768, 1, 1, 372736};
      regs[3] = '{0, 1023, 65535, 0, 5, 524287};
      regs[4] = '{777, 300, 12000, 127, 2, 200000};
      regs[5] = '{640, 480, 16384, 2, 127, 150000};
      send_idle_pct = 26;
      recv_idle_pct = 51;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < FILL_CELLS; i++) write_cell(i, $urandom_range(0, 99) < 30);
      write_cell(0, 1);
      write_cell(CELL_COUNT - 1, 0);
      // With the reset map the first four rays stay in the lower half of x and march
      // toward smaller x, and the others start off the map, so they only probe cells that were written.
      cast(16'd0, 16'd0, 16'hC000, 10'd0);
      cast(16'd7000, 16'd8000, 16'hC000, 10'd160);
      cast(16'd8191, 16'd100, 16'h9000, 10'd319);
      cast(16'd5000, 16'd16000, 16'hF000, 10'd100);
      cast(16'hFFFF, 16'hFFFF, 16'h8000, 10'd0);
      write_cell(CELL_COUNT - 1, 1);
      cast(16'd60000, 16'd60000, 16'h2000, 10'd500);
      drain();

      for (int p = 0; p < 9; p++) begin
         int ph;
         ph = p % 6;
         if (p == 3) begin
            send_idle_pct = 51;
            recv_idle_pct = 26;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int r = 0; r < 6; r++) write_reg(3'(r), regs[ph][r]);
         repeat ((p == 0) ? 26 : 17) random_beat();
         drain();
      end

      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.columns_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
